[sv/ultrasonic_range_median_assert.svh]
// Assertion macros used by the ultrasonic range median top module.
`ifndef ULTRASONIC_RANGE_MEDIAN_ASSERT_SVH
`define ULTRASONIC_RANGE_MEDIAN_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define URM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define URM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/urm_pkg.sv]
// Types and constants shared by the ultrasonic range median block.
`default_nettype none

package urm_pkg;

  // Field and counter widths
  localparam int SAMPLE_W   = 16;
  localparam int PING_W     = 20;
  localparam int TIMEOUT_W  = 16;
  localparam int STALE_W    = 22;
  localparam int SCALE_W    = 16;
  localparam int TRIG_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 22;
  localparam int TICK_US    = 1;

  // Register reset values
  localparam logic [PING_W-1:0]    PING_RST    = PING_W'(70000);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(25000);
  localparam logic [STALE_W-1:0]   STALE_RST   = STALE_W'(350000);
  localparam logic [SCALE_W-1:0]   SCALE_RST   = SCALE_W'(11239);
  localparam logic [SAMPLE_W-1:0]  INVALID_RST = SAMPLE_W'(65535);
  localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(10);

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PING_INTERVAL = 3'd0,
    REG_ECHO_TIMEOUT  = 3'd1,
    REG_STALE_LIMIT   = 3'd2,
    REG_MM_SCALE      = 3'd3,
    REG_INVALID_CODE  = 3'd4,
    REG_TRIGGER_LEN   = 3'd5
  } urm_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_LOAD,
    ST_RANK,
    ST_FINISH
  } urm_state_t;

  // Commands from the sequencer to every window cell
  typedef struct packed {
    logic shift;  // push a new sample in at cell 0
    logic load;   // park own value in the visitor slot, clear rank
    logic step;   // rotate visitors one cell, count smaller ones
  } urm_cell_ctl_t;

endpackage

`default_nettype wire

[sv/urm_cell.sv]
// One window cell: holds a sample and ranks it against values passing by.
`default_nettype none

module urm_cell
  import urm_pkg::*;
#(
  parameter int DEPTH = 5,
  parameter int IDX   = 0
) (
  input  wire logic                            clk,
  input  wire urm_cell_ctl_t                   ctl,
  input  wire logic [$clog2(DEPTH+1)-1:0]      fill,
  input  wire logic [SAMPLE_W-1:0]             shift_in,
  output logic      [SAMPLE_W-1:0]             own_val,
  input  wire logic [SAMPLE_W-1:0]             vis_in_val,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] vis_in_idx,
  output logic      [SAMPLE_W-1:0]             vis_out_val,
  output logic      [((DEPTH>1)?$clog2(DEPTH):1)-1:0] vis_out_idx,
  output logic                                 hit
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [SAMPLE_W-1:0] own_r, own_nxt;
  logic [SAMPLE_W-1:0] vis_val_r, vis_val_nxt;
  logic [IDX_W-1:0]    vis_idx_r, vis_idx_nxt;
  logic [IDX_W-1:0]    rank_r, rank_nxt;
  logic                smaller;

  // Visitor counts against this cell if it is filled and sorts ahead of it;
  // equal values break the tie by cell position.
  assign smaller = (CNT_W'(vis_idx_r) < fill) &&
                   ((vis_val_r < own_r) ||
                    ((vis_val_r == own_r) && (vis_idx_r < IDX_W'(IDX))));

  always_comb begin
    own_nxt     = own_r;
    vis_val_nxt = vis_val_r;
    vis_idx_nxt = vis_idx_r;
    rank_nxt    = rank_r;
    if (ctl.shift) begin
      own_nxt = shift_in;
    end
    if (ctl.load) begin
      vis_val_nxt = own_r;
      vis_idx_nxt = IDX_W'(IDX);
      rank_nxt    = '0;
    end else if (ctl.step) begin
      vis_val_nxt = vis_in_val;
      vis_idx_nxt = vis_in_idx;
      if (smaller) begin
        rank_nxt = rank_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    own_r     <= own_nxt;
    vis_val_r <= vis_val_nxt;
    vis_idx_r <= vis_idx_nxt;
    rank_r    <= rank_nxt;
  end

  assign own_val     = own_r;
  assign vis_out_val = vis_val_r;
  assign vis_out_idx = vis_idx_r;
  // Filled cell whose rank is the upper middle of the filled count
  assign hit = (CNT_W'(IDX) < fill) && (rank_r == IDX_W'(fill >> 1));

endmodule

`default_nettype wire

[sv/urm_window.sv]
// Sample window built as a chain of ranking cells, with median pick-off.
`default_nettype none

module urm_window
  import urm_pkg::*;
#(
  parameter int DEPTH = 5
) (
  input  wire logic                       clk,
  input  wire urm_cell_ctl_t              ctl,
  input  wire logic [$clog2(DEPTH+1)-1:0] fill,
  input  wire logic [SAMPLE_W-1:0]        sample_in,
  output logic      [SAMPLE_W-1:0]        median
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SAMPLE_W-1:0] own_val [DEPTH];
  logic [SAMPLE_W-1:0] vis_val [DEPTH];
  logic [IDX_W-1:0]    vis_idx [DEPTH];
  logic [DEPTH-1:0]    hit;

  // Cell 0 takes the newest sample; visitors circulate around a ring
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    urm_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .fill        (fill),
      .shift_in    ((i == 0) ? sample_in : own_val[(i + DEPTH - 1) % DEPTH]),
      .own_val     (own_val[i]),
      .vis_in_val  (vis_val[(i + DEPTH - 1) % DEPTH]),
      .vis_in_idx  (vis_idx[(i + DEPTH - 1) % DEPTH]),
      .vis_out_val (vis_val[i]),
      .vis_out_idx (vis_idx[i]),
      .hit         (hit[i])
    );
  end

  // Ranks are unique, so at most one cell hits
  always_comb begin
    median = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        median = median | own_val[i];
      end
    end
  end

endmodule

`default_nettype wire

[sv/ultrasonic_range_median.sv]
// Ultrasonic echo ranging with a median filter over the last few echo distances.
//
// Each input beat is one microsecond tick carrying the sampled echo level in
// in_tdata[0]. The block drives a trigger pulse every ping interval, times the
// echo high time, scales a good width to millimetres and keeps the latest
// WINDOW_DEPTH distances in a chain of cells. Every tick yields one output
// beat with trigger, the median distance (upper middle for an even count) or
// the invalid code, a reading-valid flag and a new-sample flag. From acceptance
// to the next accept a tick passes the tick update, the sample shift, a visitor
// load, WINDOW_DEPTH ranking steps as values rotate around the cell ring, and
// the result load, held while the output register is full. The finished beat
// waits there while the next tick is accepted. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata while idle: a user rule that the block does not enforce.
`default_nettype none

module ultrasonic_range_median
  import urm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Tick input
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] echo_level, [7:1] zero
  // Result output
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [23:0]           out_tdata,  // [0] trigger, [16:1] distance_mm,
                                                 // [17] new_sample, [23:18] zero
  output logic      [0:0]            out_tuser   // [0] reading_valid
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  `include "ultrasonic_range_median_assert.svh"

  // Configuration registers
  logic [PING_W-1:0]    ping_interval_r;
  logic [TIMEOUT_W-1:0] echo_timeout_r;
  logic [STALE_W-1:0]   stale_limit_r;
  logic [SCALE_W-1:0]   mm_scale_r;
  logic [SAMPLE_W-1:0]  invalid_code_r;
  logic [TRIG_W-1:0]    trigger_len_r;

  // Tick state
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [PING_W-1:0]    since_ping_r, since_ping_nxt;
  logic [STALE_W-1:0]   since_valid_r, since_valid_nxt;
  logic [TIMEOUT_W-1:0] echo_width_r, echo_width_nxt;
  logic                 echo_started_r, echo_started_nxt;
  logic                 last_echo_r, last_echo_nxt;
  logic [TRIG_W-1:0]    trigger_left_r, trigger_left_nxt;

  // Per-tick results carried to the output
  logic [31:0]          prod_r, prod_nxt;
  logic                 acc_r, acc_nxt;
  logic                 trig_r, trig_nxt;
  logic                 valid_r, valid_nxt;

  // Sequencer
  urm_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     step_cnt_r, step_cnt_nxt;
  urm_cell_ctl_t        cell_ctl;
  logic                 take;
  logic                 out_load;
  logic                 rank_last;

  // Output register
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [23:0]          out_tdata_r, out_tdata_nxt;
  logic                 out_tuser_r, out_tuser_nxt;

  logic [SAMPLE_W-1:0]  median;
  logic [PING_W:0]      ping_sum;
  logic [STALE_W:0]     stale_sum;
  logic [TIMEOUT_W:0]   width_sum;
  logic                 level;

  assign take      = in_tvalid && in_tready;
  assign level     = in_tdata[0];
  assign rank_last = (step_cnt_r == IDX_W'(WINDOW_DEPTH - 1));

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_interval_r <= PING_RST;
      echo_timeout_r  <= TIMEOUT_RST;
      stale_limit_r   <= STALE_RST;
      mm_scale_r      <= SCALE_RST;
      invalid_code_r  <= INVALID_RST;
      trigger_len_r   <= TRIG_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PING_INTERVAL: ping_interval_r <= cfg_wdata[PING_W-1:0];
        REG_ECHO_TIMEOUT:  echo_timeout_r  <= cfg_wdata[TIMEOUT_W-1:0];
        REG_STALE_LIMIT:   stale_limit_r   <= cfg_wdata[STALE_W-1:0];
        REG_MM_SCALE:      mm_scale_r      <= cfg_wdata[SCALE_W-1:0];
        REG_INVALID_CODE:  invalid_code_r  <= cfg_wdata[SAMPLE_W-1:0];
        REG_TRIGGER_LEN:   trigger_len_r   <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the tick state: counters, echo edge, ping, trigger, validity
  assign ping_sum  = {1'b0, since_ping_r} + (PING_W + 1)'(TICK_US);
  assign stale_sum = {1'b0, since_valid_r} + (STALE_W + 1)'(TICK_US);
  assign width_sum = {1'b0, echo_width_r} + (TIMEOUT_W + 1)'(1);

  always_comb begin
    since_ping_nxt   = since_ping_r;
    since_valid_nxt  = since_valid_r;
    echo_width_nxt   = echo_width_r;
    echo_started_nxt = echo_started_r;
    last_echo_nxt    = last_echo_r;
    trigger_left_nxt = trigger_left_r;
    fill_nxt         = fill_r;
    prod_nxt         = prod_r;
    acc_nxt          = acc_r;
    trig_nxt         = trig_r;
    valid_nxt        = valid_r;
    if (take) begin
      since_ping_nxt  = ping_sum[PING_W] ? '1 : ping_sum[PING_W-1:0];
      since_valid_nxt = stale_sum[STALE_W] ? '1 : stale_sum[STALE_W-1:0];
      acc_nxt         = 1'b0;
      prod_nxt        = {16'd0, echo_width_r} * {16'd0, mm_scale_r};
      if (level && !last_echo_r) begin
        echo_started_nxt = 1'b1;
        echo_width_nxt   = TIMEOUT_W'(1);
      end else if (level && last_echo_r) begin
        echo_width_nxt = width_sum[TIMEOUT_W] ? '1 : width_sum[TIMEOUT_W-1:0];
      end else if (!level && last_echo_r && echo_started_r) begin
        echo_started_nxt = 1'b0;
        if ((echo_width_r != '0) && (echo_width_r < echo_timeout_r)) begin
          acc_nxt         = 1'b1;
          since_valid_nxt = '0;
          if (fill_r < CNT_W'(WINDOW_DEPTH)) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
      last_echo_nxt = level;
      // Ping restarts the interval and the trigger pulse
      if (since_ping_nxt >= ping_interval_r) begin
        since_ping_nxt   = '0;
        echo_started_nxt = 1'b0;
        echo_width_nxt   = '0;
        trigger_left_nxt = trigger_len_r;
      end
      trig_nxt = (trigger_left_nxt != '0);
      if (trigger_left_nxt != '0) begin
        trigger_left_nxt = trigger_left_nxt - TRIG_W'(1);
      end
      valid_nxt = (fill_nxt != '0) && (since_valid_nxt <= stale_limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r         <= '0;
      since_ping_r   <= '0;
      since_valid_r  <= '0;
      echo_width_r   <= '0;
      echo_started_r <= 1'b0;
      last_echo_r    <= 1'b0;
      trigger_left_r <= '0;
      acc_r          <= 1'b0;
      trig_r         <= 1'b0;
      valid_r        <= 1'b0;
    end else begin
      fill_r         <= fill_nxt;
      since_ping_r   <= since_ping_nxt;
      since_valid_r  <= since_valid_nxt;
      echo_width_r   <= echo_width_nxt;
      echo_started_r <= echo_started_nxt;
      last_echo_r    <= last_echo_nxt;
      trigger_left_r <= trigger_left_nxt;
      acc_r          <= acc_nxt;
      trig_r         <= trig_nxt;
      valid_r        <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt    = ST_RANK;
        step_cnt_nxt = '0;
      end
      ST_RANK: begin
        if (rank_last) begin
          state_nxt = ST_FINISH;
        end else begin
          step_cnt_nxt = step_cnt_r + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready      = 1'b0;
    cell_ctl.shift = 1'b0;
    cell_ctl.load  = 1'b0;
    cell_ctl.step  = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready      = 1'b1;
      ST_WRITE:  cell_ctl.shift = acc_r;
      ST_LOAD:   cell_ctl.load  = 1'b1;
      ST_RANK:   cell_ctl.step  = 1'b1;
      ST_FINISH: out_load       = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  urm_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk       (clk),
    .ctl       (cell_ctl),
    .fill      (fill_r),
    .sample_in (prod_r[31:16]),
    .median    (median)
  );

  // Hold the result beat until taken; load a new one when the slot frees
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {6'd0, acc_r, (valid_r ? median : invalid_code_r), trig_r};
      out_tuser_nxt  = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

  // Checks on the sequencer and window fill
  `URM_ASSERT_NEXT(a_take_starts_write, take, state_r == ST_WRITE, "tick did not start a write")
  `URM_ASSERT_NOW(a_beat_from_finish, $rose(out_tvalid_r), $past(state_r == ST_FINISH), "result beat raised outside finish")
  `URM_ASSERT_NOW(a_fill_bounded, 1'b1, fill_r <= CNT_W'(WINDOW_DEPTH), "window fill beyond depth")
  `URM_ASSERT_NEXT(a_rank_ends, (state_r == ST_RANK) && rank_last, state_r == ST_FINISH, "ranking did not end")

endmodule

`default_nettype wire
